// File: design/csiu_pkg.sv
// ----------------------------------------------------------------------------
// csiu_pkg
// shared widths, request codes, pin numbers and the command/status structs
// of the serial-bit systems interface unit
// ----------------------------------------------------------------------------
package csiu_pkg;

  localparam int ADDR_W   = 12;
  localparam int SADDR_W  = ADDR_W + 1;   // serial address counter, no wrap
  localparam int DATA_W   = 16;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = 4;
  localparam int KEY_W    = 64;
  localparam int PIN_N    = 32;
  localparam int PIN_W    = 5;
  localparam int TIMER_W  = 14;
  localparam int REQ_W    = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_V_RAISE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_V_CLEAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_T_RAISE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_T_CLEAR = 3'd5;

  // internal bit numbers
  localparam logic [PIN_W-1:0] MODE_PIN       = 5'd0;
  localparam logic [PIN_W-1:0] ONE_PIN        = 5'd1;
  localparam logic [PIN_W-1:0] VIDEO_PIN      = 5'd2;
  localparam logic [PIN_W-1:0] TIMER_PIN      = 5'd3;
  localparam logic [PIN_W-1:0] ROW_FIRST      = 5'd3;
  localparam logic [PIN_W-1:0] ROW_LAST       = 5'd10;
  localparam logic [PIN_W-1:0] ALPHA_ROW_PIN  = 5'd7;
  localparam logic [PIN_W-1:0] TIMER_LAST     = 5'd14;
  localparam logic [PIN_W-1:0] SOFT_RESET_PIN = 5'd15;
  localparam logic [PIN_W-1:0] ALIAS_FIRST    = 5'd23;
  localparam logic [PIN_W-1:0] ALIAS_DROP     = 5'd8;
  localparam int               COL1_PIN       = 18;
  localparam int               COL3_PIN       = 20;
  localparam int               ALPHA_PIN      = 21;

  // one bit access or interrupt operation per cycle
  typedef struct packed {
    logic                en;
    logic [REQ_W-1:0]    req;
    logic [SADDR_W-1:0]  addr;
    logic                wbit;
    logic [KEY_W-1:0]    keys;
    logic                caps;
  } cmd_t;

  typedef struct packed {
    logic rbit;
    logic video_line;
    logic timer_line;
  } stat_t;

endpackage

// File: design/csiu_bit_unit.sv
// ----------------------------------------------------------------------------
// csiu_bit_unit
// holds the 32 internal bits, timer and interrupt state; performs one serial
// bit read or write, or one interrupt raise/clear, per enabled cycle
// ----------------------------------------------------------------------------
module csiu_bit_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  csiu_pkg::cmd_t cmd,
  output csiu_pkg::stat_t stat
);

  logic [csiu_pkg::PIN_N-1:0]   pins_r, pins_nxt;
  logic [csiu_pkg::TIMER_W-1:0] start_r, start_nxt;
  logic [csiu_pkg::TIMER_W-1:0] count_r, count_nxt;
  logic vp_r, vp_nxt, tp_r, tp_nxt, vl_r, vl_nxt, tl_r, tl_nxt;

  logic                          ext;
  logic [csiu_pkg::PIN_W-1:0]    a;
  logic [csiu_pkg::PIN_W-1:0]    aa;
  logic [csiu_pkg::PIN_W-1:0]    tbit;
  logic [csiu_pkg::PIN_W-1:0]    row;
  logic [2:0]                    col;
  logic                          rbit;

  assign ext  = |cmd.addr[csiu_pkg::SADDR_W-1:10];
  assign a    = cmd.addr[csiu_pkg::PIN_W-1:0];
  assign tbit = a - 5'd1;
  assign aa   = (a >= csiu_pkg::ALIAS_FIRST) ? a - csiu_pkg::ALIAS_DROP : a;
  assign row  = aa - csiu_pkg::ROW_FIRST;
  assign col  = pins_r[csiu_pkg::COL3_PIN:csiu_pkg::COL1_PIN];

  // read path
  always_comb begin
    rbit = 1'b1;
    if (ext) begin
      rbit = 1'b1;
    end else if (pins_r[csiu_pkg::MODE_PIN]) begin
      if (a == csiu_pkg::MODE_PIN) begin
        rbit = 1'b1;
      end else if (a == csiu_pkg::SOFT_RESET_PIN) begin
        rbit = !((vp_r && pins_r[csiu_pkg::VIDEO_PIN]) ||
                 (tp_r && pins_r[csiu_pkg::TIMER_PIN]));
      end else if (a <= csiu_pkg::TIMER_LAST) begin
        rbit = count_r[tbit[3:0]];
      end else begin
        rbit = 1'b0;
      end
    end else begin
      if (aa == csiu_pkg::MODE_PIN) begin
        rbit = 1'b0;
      end else if (aa == csiu_pkg::ONE_PIN) begin
        rbit = 1'b1;
      end else if (aa == csiu_pkg::VIDEO_PIN) begin
        rbit = !vp_r;
      end else if (aa inside {[csiu_pkg::ROW_FIRST:csiu_pkg::ROW_LAST]}) begin
        rbit = 1'b1;
        if (aa == csiu_pkg::ALPHA_ROW_PIN && !pins_r[csiu_pkg::ALPHA_PIN] && cmd.caps) begin
          rbit = 1'b0;
        end
        if (cmd.keys[{row[2:0], col}]) begin
          rbit = 1'b0;
        end
      end else begin
        rbit = pins_r[aa];
      end
    end
  end

  // state update
  always_comb begin
    pins_nxt  = pins_r;
    start_nxt = start_r;
    count_nxt = count_r;
    vp_nxt    = vp_r;
    tp_nxt    = tp_r;
    vl_nxt    = vl_r;
    tl_nxt    = tl_r;
    if (cmd.en) begin
      case (cmd.req)
        csiu_pkg::REQ_WRITE: begin
          if (!ext) begin
            if (a == csiu_pkg::MODE_PIN) begin
              pins_nxt[csiu_pkg::MODE_PIN] = cmd.wbit;
            end else if (pins_r[csiu_pkg::MODE_PIN]) begin
              if (a == csiu_pkg::SOFT_RESET_PIN) begin
                pins_nxt[3:0] = 4'd0;
                start_nxt     = '0;
                count_nxt     = '0;
              end else if (a <= csiu_pkg::TIMER_LAST) begin
                start_nxt[tbit[3:0]] = cmd.wbit;
                count_nxt            = start_nxt;
              end else begin
                pins_nxt[csiu_pkg::MODE_PIN] = 1'b0;
              end
            end else begin
              pins_nxt[a] = cmd.wbit;
              if (a == csiu_pkg::TIMER_PIN) begin
                if (tp_r) begin
                  tp_nxt = 1'b0;
                  if (cmd.wbit) tl_nxt = 1'b0;
                end
              end else if (a == csiu_pkg::VIDEO_PIN && cmd.wbit) begin
                vl_nxt = vp_r;
              end
            end
          end
        end
        csiu_pkg::REQ_V_RAISE: begin
          if (!vp_r) begin
            vp_nxt = 1'b1;
            if (pins_r[csiu_pkg::VIDEO_PIN]) vl_nxt = 1'b1;
          end
        end
        csiu_pkg::REQ_V_CLEAR: begin
          if (vp_r) begin
            vp_nxt = 1'b0;
            if (pins_r[csiu_pkg::VIDEO_PIN]) vl_nxt = 1'b0;
          end
        end
        csiu_pkg::REQ_T_RAISE: begin
          if (!tp_r) begin
            tp_nxt = 1'b1;
            if (pins_r[csiu_pkg::TIMER_PIN]) tl_nxt = 1'b1;
          end
        end
        csiu_pkg::REQ_T_CLEAR: begin
          if (tp_r) begin
            tp_nxt = 1'b0;
            if (pins_r[csiu_pkg::TIMER_PIN]) tl_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r  <= '0;
      start_r <= '0;
      count_r <= '0;
      vp_r    <= 1'b0;
      tp_r    <= 1'b0;
      vl_r    <= 1'b0;
      tl_r    <= 1'b0;
    end else begin
      pins_r  <= pins_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      vp_r    <= vp_nxt;
      tp_r    <= tp_nxt;
      vl_r    <= vl_nxt;
      tl_r    <= tl_nxt;
    end
  end

  assign stat.rbit       = rbit;
  assign stat.video_line = vl_r;
  assign stat.timer_line = tl_r;

endmodule

// File: design/cru_systems_interface_unit.sv
// ----------------------------------------------------------------------------
// cru_systems_interface_unit
// serial-bit systems interface unit: a sequencer steps a shared bit unit over
// up to sixteen consecutive serial addresses per word
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   req_type, bit_address, write_bits,
//                                          bit_count, key_matrix, caps_locked
//  out_     output     out_valid/out_stall read_bits, video_irq_line,
//                                          timer_irq_line
//
// a read or write word steps the bit unit over its n bits (n = 1..16, one
// bit per cycle through the bit unit), then posts the result; an interrupt
// raise/clear makes one pass through the bit unit, then posts its result
// in_stall is high from acceptance until the result is posted
// the result sits in an output register; a stalled output holds the
// sequencer in its post state, so at most one word waits there
// synchronous active-low reset clears all internal bits, timer and interrupts
//
module cru_systems_interface_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csiu_pkg::REQ_W-1:0]    in_req_type,
  input  logic [csiu_pkg::ADDR_W-1:0]   in_bit_address,
  input  logic [csiu_pkg::DATA_W-1:0]   in_write_bits,
  input  logic [csiu_pkg::CNT_W-1:0]    in_bit_count,
  input  logic [csiu_pkg::KEY_W-1:0]    in_key_matrix,
  input  logic                          in_caps_locked,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csiu_pkg::DATA_W-1:0]   out_read_bits,
  output logic                          out_video_irq_line,
  output logic                          out_timer_irq_line
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0] state_r, state_nxt;

  // word being worked on
  logic [csiu_pkg::REQ_W-1:0]   req_r;
  logic [csiu_pkg::SADDR_W-1:0] addr_r;
  logic [csiu_pkg::DATA_W-1:0]  wdata_r;
  logic [csiu_pkg::DATA_W-1:0]  rdata_r;
  logic [csiu_pkg::IDX_W-1:0]   idx_r;
  logic [csiu_pkg::IDX_W-1:0]   last_r;
  logic [csiu_pkg::KEY_W-1:0]   keys_r;
  logic                         caps_r;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [csiu_pkg::DATA_W-1:0]  out_rdata_r;
  logic                         out_vl_r;
  logic                         out_tl_r;

  logic             accept;
  logic             serial;     // read or write, stepped over the bits
  logic             step_done;
  logic             post;
  logic [csiu_pkg::IDX_W-1:0] last_in;
  csiu_pkg::cmd_t   cmd;
  csiu_pkg::stat_t  stat;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign serial    = (req_r == csiu_pkg::REQ_WRITE) || (req_r == csiu_pkg::REQ_READ);
  assign step_done = !serial || (idx_r == last_r);
  assign post      = (state_r == ST_POST) && (!out_valid_r || !out_stall);

  // zero or above sixteen both mean a full sixteen-bit transfer
  assign last_in = (in_bit_count == '0 || in_bit_count > 5'd16) ?
                   4'd15 : 4'(in_bit_count - 5'd1);

  // one operation per cycle into the bit unit while the sequencer runs
  assign cmd.en   = (state_r == ST_RUN);
  assign cmd.req  = req_r;
  assign cmd.addr = addr_r;
  assign cmd.wbit = wdata_r[idx_r];
  assign cmd.keys = keys_r;
  assign cmd.caps = caps_r;

  csiu_bit_unit u_bit_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (step_done) state_nxt = ST_POST;
      ST_POST: if (post) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register empties when taken, fills when a word is posted
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (post) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // word registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      addr_r  <= {1'b0, in_bit_address};
      wdata_r <= in_write_bits;
      rdata_r <= '0;
      idx_r   <= '0;
      last_r  <= last_in;
      keys_r  <= in_key_matrix;
      caps_r  <= in_caps_locked;
    end else if (state_r == ST_RUN) begin
      if (req_r == csiu_pkg::REQ_READ) rdata_r[idx_r] <= stat.rbit;
      // address counter has a spare top bit, so it steps on without wrapping back out of the external area
      addr_r <= addr_r + 13'd1;
      idx_r  <= idx_r + 4'd1;
    end
    if (post) begin
      out_rdata_r <= rdata_r;
      out_vl_r    <= stat.video_line;
      out_tl_r    <= stat.timer_line;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_bits      = out_rdata_r;
  assign out_video_irq_line = out_vl_r;
  assign out_timer_irq_line = out_tl_r;

endmodule

// File: test/cru_systems_interface_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cru_systems_interface_unit_tb
// self-checking bench for the serial-bit systems interface unit: a queue of
// request words feeds a clocked driver, a bit-level model of the 32 internal
// bits, timer and interrupt lines predicts every reply, and a clocked monitor
// checks each reply field by field under random gaps and output stalls
// ----------------------------------------------------------------------------
module cru_systems_interface_unit_tb;
  import csiu_pkg::*;

  // request codes the unit does not know; they must leave all state alone
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam int RANDOM_WORDS = 1400;
  localparam int HOLD_AT_REPLY = 200;   // reply count at which the long hold starts
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  // one request word as offered on the input channel
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic [KEY_W-1:0]  keys;
    logic              caps;
    int                gap;      // idle cycles before this word is offered
  } cru_word_t;

  // one reply word as seen on the result channel
  typedef struct packed {
    logic [DATA_W-1:0] read_bits;
    logic              video;
    logic              timer;
  } cru_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [ADDR_W-1:0]   in_bit_address = '0;
  logic [DATA_W-1:0]   in_write_bits = '0;
  logic [CNT_W-1:0]    in_bit_count = '0;
  logic [KEY_W-1:0]    in_key_matrix = '0;
  logic                in_caps_locked = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   out_read_bits;
  logic                out_video_irq_line;
  logic                out_timer_irq_line;

  cru_systems_interface_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_bit_address     (in_bit_address),
    .in_write_bits      (in_write_bits),
    .in_bit_count       (in_bit_count),
    .in_key_matrix      (in_key_matrix),
    .in_caps_locked     (in_caps_locked),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_bits      (out_read_bits),
    .out_video_irq_line (out_video_irq_line),
    .out_timer_irq_line (out_timer_irq_line)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // bit-level model of the unit; state matches the post-reset contents
  // --------------------------------------------------------------------------
  logic [PIN_N-1:0]   pins = '0;          // pin 0 high means timer mode
  logic [TIMER_W-1:0] tmr_start = '0;
  logic [TIMER_W-1:0] tmr_count = '0;
  logic               vid_pend = 1'b0;
  logic               tmr_pend = 1'b0;
  logic               vid_line = 1'b0;
  logic               tmr_line = 1'b0;

  // dropping a pending timer interrupt only moves the line when its mask is set
  function automatic void clear_timer_irq();
    if (tmr_pend) begin
      tmr_pend = 1'b0;
      if (pins[TIMER_PIN]) tmr_line = 1'b0;
    end
  endfunction

  function automatic void pin_write(input logic [SADDR_W-1:0] sa, input logic b);
    logic [PIN_W-1:0] a;
    a = sa[PIN_W-1:0];
    // external area: writes go nowhere
    if (sa[SADDR_W-1:10] != '0) return;
    if (a == MODE_PIN) begin
      pins[MODE_PIN] = b;
    end else if (pins[MODE_PIN]) begin
      if (a == SOFT_RESET_PIN) begin
        // soft reset: low pins and timer cleared, unit drops back to i/o mode
        pins[3:0] = '0;
        tmr_count = '0;
        tmr_start = '0;
      end else if (a <= TIMER_LAST) begin
        tmr_start[a-1] = b;
        tmr_count = tmr_start;
      end else begin
        // upper bits in timer mode only leave timer mode
        pins[MODE_PIN] = 1'b0;
      end
    end else begin
      pins[a] = b;
      if (a == TIMER_PIN) clear_timer_irq();
      else if (a == VIDEO_PIN && b) vid_line = vid_pend;
    end
  endfunction

  function automatic logic pin_read(input logic [SADDR_W-1:0] sa,
                                    input logic [KEY_W-1:0] keys, input logic caps);
    logic [PIN_W-1:0] a;
    logic [2:0]       col;
    logic             r;
    int               idx;
    a = sa[PIN_W-1:0];
    if (sa[SADDR_W-1:10] != '0) return 1'b1;
    if (pins[MODE_PIN]) begin
      if (a == MODE_PIN) return 1'b1;
      if (a == SOFT_RESET_PIN)
        return !((vid_pend && pins[VIDEO_PIN]) || (tmr_pend && pins[TIMER_PIN]));
      if (a <= TIMER_LAST) return tmr_count[a-1];
      return 1'b0;
    end
    // upper pins fold down onto 15..23
    if (a >= ALIAS_FIRST) a = a - ALIAS_DROP;
    if (a == MODE_PIN) return 1'b0;
    if (a == ONE_PIN) return 1'b1;
    if (a == VIDEO_PIN) return !vid_pend;
    if (a >= ROW_FIRST && a <= ROW_LAST) begin
      r = 1'b1;
      if (a == ALPHA_ROW_PIN && !pins[ALPHA_PIN] && caps) r = 1'b0;
      col = pins[COL3_PIN:COL1_PIN];
      idx = (a - ROW_FIRST) * 8 + col;
      if (keys[idx]) r = 1'b0;
      return r;
    end
    return pins[a];
  endfunction

  // applies one accepted word to the model and returns the reply it causes
  function automatic cru_reply_t cru_access(input cru_word_t w);
    cru_reply_t       rep;
    int               n;
    logic [SADDR_W-1:0] sa;
    rep.read_bits = '0;
    n = (w.cnt == 0 || w.cnt > 16) ? 16 : int'(w.cnt);
    case (w.req)
      REQ_WRITE: begin
        for (int i = 0; i < n; i++) begin
          sa = SADDR_W'(w.addr) + SADDR_W'(i);
          pin_write(sa, w.data[i]);
        end
      end
      REQ_READ: begin
        for (int i = 0; i < n; i++) begin
          sa = SADDR_W'(w.addr) + SADDR_W'(i);
          rep.read_bits[i] = pin_read(sa, w.keys, w.caps);
        end
      end
      REQ_V_RAISE: begin
        if (!vid_pend) begin
          vid_pend = 1'b1;
          if (pins[VIDEO_PIN]) vid_line = 1'b1;
        end
      end
      REQ_V_CLEAR: begin
        if (vid_pend) begin
          vid_pend = 1'b0;
          if (pins[VIDEO_PIN]) vid_line = 1'b0;
        end
      end
      REQ_T_RAISE: begin
        if (!tmr_pend) begin
          tmr_pend = 1'b1;
          if (pins[TIMER_PIN]) tmr_line = 1'b1;
        end
      end
      REQ_T_CLEAR: clear_timer_irq();
      default: ;
    endcase
    rep.video = vid_line;
    rep.timer = tmr_line;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // word queue, reply queue and run bookkeeping
  // --------------------------------------------------------------------------
  cru_word_t  request_q[$];
  cru_reply_t reply_q[$];
  cru_word_t  cur_word;
  int         word_total = 0;
  int         accepted = 0;
  int         replies = 0;
  int         errors = 0;
  int         n_writes = 0, n_reads = 0, n_irq_ops = 0, n_spare = 0, n_timer_mode = 0;

  // sender idles in two stretches out of three, runs back to back in the third
  task automatic push_req(input logic [REQ_W-1:0] rq, input logic [ADDR_W-1:0] ad,
                          input logic [DATA_W-1:0] wd, input logic [CNT_W-1:0] bc,
                          input logic [KEY_W-1:0] km, input logic cl);
    cru_word_t w;
    w.req = rq;
    w.addr = ad;
    w.data = wd;
    w.cnt = bc;
    w.keys = km;
    w.caps = cl;
    w.gap = ((request_q.size() / 90) % 3 == 2) ? 0 : $urandom_range(0, 14);
    request_q.push_back(w);
    word_total++;
  endtask

  // key matrix: mostly random, sometimes empty, a single key or everything
  function automatic logic [KEY_W-1:0] rand_keys();
    logic [KEY_W-1:0] k;
    int               sel;
    sel = $urandom_range(0, 9);
    k = {$urandom, $urandom};
    if (sel == 0) k = '0;
    else if (sel == 1) k = '1;
    else if (sel <= 3) k = 64'd1 << $urandom_range(0, 63);
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers queued words, holds payload while stalled
  // --------------------------------------------------------------------------
  int idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        // word taken this edge: run it through the model
        if (pins[MODE_PIN] && (cur_word.req == REQ_WRITE || cur_word.req == REQ_READ))
          n_timer_mode++;
        case (cur_word.req)
          REQ_WRITE: n_writes++;
          REQ_READ: n_reads++;
          REQ_SPARE_A, REQ_SPARE_B: n_spare++;
          default: n_irq_ops++;
        endcase
        reply_q.push_back(cru_access(cur_word));
        accepted++;
      end
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_word = request_q.pop_front();
        in_req_type <= cur_word.req;
        in_bit_address <= cur_word.addr;
        in_write_bits <= cur_word.data;
        in_bit_count <= cur_word.cnt;
        in_key_matrix <= cur_word.keys;
        in_caps_locked <= cur_word.caps;
        in_valid <= 1'b1;
        idle_left = (request_q.size() > 0) ? request_q[0].gap : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks replies in order and draws its own stall per reply
  // --------------------------------------------------------------------------
  int         stall_left = 0;
  cru_reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply with nothing expected: read_bits %h video %b timer %b",
                   $time, out_read_bits, out_video_irq_line, out_timer_irq_line);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_read_bits !== want.read_bits) begin
            $display("%0t: read_bits expected %h got %h", $time, want.read_bits,
                     out_read_bits);
            errors++;
          end
          if (out_video_irq_line !== want.video) begin
            $display("%0t: video_irq_line expected %b got %b", $time, want.video,
                     out_video_irq_line);
            errors++;
          end
          if (out_timer_irq_line !== want.timer) begin
            $display("%0t: timer_irq_line expected %b got %b", $time, want.timer,
                     out_timer_irq_line);
            errors++;
          end
        end
        replies++;
        // one long hold so the unit backs up and stalls its input,
        // otherwise a stall-free stretch every third block of replies
        if (replies == HOLD_AT_REPLY) stall_left = HOLD_CYCLES;
        else if ((replies / 128) % 3 == 1) stall_left = 0;
        else stall_left = $urandom_range(0, 14);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int               pick, base, sel, k;
    logic [ADDR_W-1:0] ad;
    logic [CNT_W-1:0]  bc;

    // directed words
    push_req(REQ_READ, 0, 0, 16, '0, 1'b0);             // i/o read straight after reset
    push_req(REQ_WRITE, 0, 16'hFFFE, 16, '0, 1'b0);     // masks and pins 1..15 on
    push_req(REQ_V_RAISE, 0, 0, 0, '0, 1'b0);
    push_req(REQ_T_RAISE, 0, 0, 0, '0, 1'b0);
    push_req(REQ_READ, 0, 0, 16, '1, 1'b1);             // every key down
    push_req(REQ_WRITE, 16, 16'h003F, 6, '0, 1'b0);     // column 7, alpha pin high
    push_req(REQ_WRITE, 20, 16'h0000, 2, '0, 1'b0);     // column 3, alpha lock enabled
    push_req(REQ_READ, 3, 0, 8, 64'd1 << 35, 1'b1);     // key at row 4, alpha lock on
    push_req(REQ_READ, 23, 0, 9, {$urandom, $urandom}, 1'b0);  // aliased upper pins
    push_req(REQ_V_CLEAR, 0, 0, 0, '0, 1'b0);
    push_req(REQ_T_CLEAR, 0, 0, 0, '0, 1'b0);
    push_req(REQ_SPARE_A, 5, 16'hFFFF, 16, '1, 1'b1);
    push_req(REQ_SPARE_B, 0, 16'h0001, 1, '0, 1'b0);
    push_req(REQ_WRITE, 0, 16'h7FFF, 15, '0, 1'b0);     // timer mode, start all ones
    push_req(REQ_T_RAISE, 0, 0, 0, '0, 1'b0);
    push_req(REQ_READ, 0, 0, 31, '0, 1'b0);             // count above sixteen, timer read
    push_req(REQ_READ, 47, 0, 1, '0, 1'b0);             // mirrored soft reset bit
    push_req(REQ_WRITE, 16, 0, 1, '0, 1'b0);            // upper bit leaves timer mode
    push_req(REQ_WRITE, 0, 16'h8001, 0, '0, 1'b0);      // soft reset on the last bit of the word
    push_req(REQ_READ, 1020, 0, 16, '0, 1'b0);          // crosses into external area
    push_req(REQ_WRITE, 1016, 16'hFFFF, 16, '0, 1'b0);
    push_req(REQ_WRITE, 4095, 16'hFFFF, 16, '0, 1'b1);
    push_req(REQ_READ, 4095, 0, 17, '1, 1'b1);
    push_req(REQ_V_RAISE, 0, 0, 0, '0, 1'b0);
    push_req(REQ_READ, 2, 0, 1, '0, 1'b0);              // video pending reads low

    // random words, with timer sessions and key scans mixed in
    while (word_total < RANDOM_WORDS + 25) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // timer session: enter at a mirror of pin 0, read back, maybe leave
        base = 32 * $urandom_range(0, 31);
        push_req(REQ_WRITE, ADDR_W'(base), {15'($urandom_range(0, 32767)), 1'b1}, 15,
                 '0, 1'b0);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 2) == 0)
            push_req(REQ_W'($urandom_range(REQ_V_RAISE, REQ_T_CLEAR)), 0, 0, 0, '0, 1'b0);
          push_req(REQ_READ, ADDR_W'(base + $urandom_range(0, 15)), 0,
                   CNT_W'($urandom_range(0, 16)), '0, 1'b0);
        end
        pick = $urandom_range(0, 2);
        if (pick == 0)
          push_req(REQ_WRITE, ADDR_W'(base + 15), DATA_W'($urandom), 1, '0, 1'b0);
        else if (pick == 1)
          push_req(REQ_WRITE, ADDR_W'(base + $urandom_range(16, 31)), DATA_W'($urandom), 1,
                   '0, 1'b0);
      end else if (sel < 18) begin
        // key scan: pick a column and alpha pin, then read the rows
        push_req(REQ_WRITE, ADDR_W'(32 * $urandom_range(0, 31) + COL1_PIN),
                 DATA_W'($urandom_range(0, 15)), 4, '0, 1'b0);
        push_req(REQ_READ, ADDR_W'(32 * $urandom_range(0, 31) + ROW_FIRST), 0, 8,
                 rand_keys(), 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, 99);
        if (k < 60) ad = ADDR_W'($urandom_range(0, 47));
        else if (k < 80) ad = ADDR_W'($urandom_range(0, 1023));
        else if (k < 92) ad = ADDR_W'($urandom_range(1000, 1040));
        else ad = ADDR_W'($urandom_range(0, 4095));
        bc = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(1, 16)) :
                                           CNT_W'($urandom_range(0, 31));
        if (pick < 40)
          push_req(REQ_WRITE, ad, DATA_W'($urandom), bc, rand_keys(),
                   1'($urandom_range(0, 1)));
        else if (pick < 75)
          push_req(REQ_READ, ad, DATA_W'($urandom), bc, rand_keys(),
                   1'($urandom_range(0, 1)));
        else if (pick < 96)
          push_req(REQ_W'($urandom_range(REQ_V_RAISE, REQ_T_CLEAR)), ad, DATA_W'($urandom),
                   bc, rand_keys(), 1'($urandom_range(0, 1)));
        else
          push_req(REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_B)), ad, DATA_W'($urandom),
                   bc, rand_keys(), 1'($urandom_range(0, 1)));
      end
    end

    // reset once, then let the driver run the queue
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < word_total || reply_q.size() != 0) @(posedge clk);
    // room for any stray reply after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d writes, %0d reads, %0d interrupt ops, %0d unknown",
             accepted, n_writes, n_reads, n_irq_ops, n_spare);
    $display("%0d serial words in timer mode, %0d replies checked, %0d mismatches",
             n_timer_mode, replies, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #800000;
    $display("timeout with %0d of %0d words accepted, %0d replies outstanding",
             accepted, word_total, reply_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
